// ===== hdl/cld_pkg.sv =====
// ----------------------------------------------------------------------------
// cld_pkg
// shared constants for the console line discipline: character codes,
// request op codes, result kinds and default store depths
// ----------------------------------------------------------------------------
package cld_pkg;

   localparam int DEF_SEND_DEPTH = 32;
   localparam int DEF_LINE_DEPTH = 32;
   localparam int LEN_W          = 6;

   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;

   localparam logic [1:0] OP_RECV  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TXRDY = 2'd2;

   localparam logic [1:0] KIND_TX   = 2'd0;
   localparam logic [1:0] KIND_LINE = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

endpackage

// ===== hdl/cld_byte_ram.sv =====
// ----------------------------------------------------------------------------
// cld_byte_ram
// byte-wide store with one write port and one registered read port
// ----------------------------------------------------------------------------
module cld_byte_ram
   import cld_pkg::*;
#(
   parameter int DEPTH = DEF_SEND_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/console_line_discipline_core.sv =====
// ----------------------------------------------------------------------------
// console_line_discipline_core
// serial console line discipline: cr to lf, echo, lf to cr lf expansion,
// transmit queue with start and ready pacing, line gathering and delivery
// ----------------------------------------------------------------------------
// a line delivery gives one stored byte per cycle while the result side
// takes them, followed by the end marker
// requests are taken one at a time, paced by the single read port of the
// line store and the output register
// reset: control state, counters, transmitter busy and attached are cleared;
// the queue and line store contents are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
module console_line_discipline_core
   import cld_pkg::*;
#(
   parameter int SEND_DEPTH = DEF_SEND_DEPTH,
   parameter int LINE_DEPTH = DEF_LINE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_op,
   input  logic [7:0]       req_data_byte,
   input  logic             req_final_byte,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_out_byte,
   output logic [LEN_W-1:0] rsp_line_length,
   output logic             rsp_overflow,
   output logic             rsp_last,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_attached
);

   localparam int SAW = $clog2(SEND_DEPTH);
   localparam int SCW = $clog2(SEND_DEPTH + 1);
   localparam int LAW = $clog2(LINE_DEPTH);
   localparam int LCW = $clog2(LINE_DEPTH + 1);

   localparam logic [SCW-1:0] SEND_FULL = SCW'(SEND_DEPTH);
   localparam logic [SAW-1:0] SEND_LAST = SAW'(SEND_DEPTH - 1);
   localparam logic [LCW-1:0] LINE_FULL = LCW'(LINE_DEPTH);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_PUSH_CR   = 4'd1;
   localparam logic [3:0] ST_PUSH_BYTE = 4'd2;
   localparam logic [3:0] ST_START     = 4'd3;
   localparam logic [3:0] ST_TXRDY     = 4'd4;
   localparam logic [3:0] ST_SEND      = 4'd5;
   localparam logic [3:0] ST_LINE      = 4'd6;
   localparam logic [3:0] ST_LINE_EMIT = 4'd7;
   localparam logic [3:0] ST_MARK      = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [7:0]       byte_ff, byte_in;
   logic             fin_ff, fin_in;
   logic             attached_ff, attached_in;
   logic             busy_ff, busy_in;
   logic             drop_ff, drop_in;
   logic [SAW-1:0]   head_ff, head_in;
   logic [SAW-1:0]   tail_ff, tail_in;
   logic [SCW-1:0]   send_count_ff, send_count_in;
   logic [LCW-1:0]   line_count_ff, line_count_in;
   logic [LAW-1:0]   line_idx_ff, line_idx_in;

   logic             out_valid_ff, out_valid_in;
   logic [1:0]       out_kind_ff, out_kind_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic [LEN_W-1:0] out_len_ff, out_len_in;
   logic             out_ovf_ff, out_ovf_in;
   logic             out_last_ff, out_last_in;

   logic             slot_free;
   logic             send_wr_en;
   logic [7:0]       send_wr_data;
   logic [7:0]       send_rd_data;
   logic             line_wr_en;
   logic [7:0]       line_rd_data;
   logic [LEN_W+LCW-1:0] line_len_wide;

   cld_byte_ram #(.DEPTH(SEND_DEPTH)) u_send_ram (
      .clock   (clock),
      .wr_en   (send_wr_en),
      .wr_addr (tail_ff),
      .wr_data (send_wr_data),
      .rd_addr (head_ff),
      .rd_data (send_rd_data)
   );

   cld_byte_ram #(.DEPTH(LINE_DEPTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (line_wr_en),
      .wr_addr (line_count_ff[LAW-1:0]),
      .wr_data (byte_ff),
      .rd_addr (line_idx_in),
      .rd_data (line_rd_data)
   );

   assign slot_free     = !out_valid_ff || rsp_ready;
   assign line_len_wide = (LEN_W+LCW)'(line_count_ff);
   assign req_ready     = (state_ff == ST_IDLE);
   assign csr_ready     = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      byte_in       = byte_ff;
      fin_in        = fin_ff;
      attached_in   = attached_ff;
      busy_in       = busy_ff;
      drop_in       = drop_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      send_count_in = send_count_ff;
      line_count_in = line_count_ff;
      line_idx_in   = line_idx_ff;
      send_wr_en    = 1'b0;
      send_wr_data  = byte_ff;
      line_wr_en    = 1'b0;

      out_valid_in  = out_valid_ff && !rsp_ready;
      out_kind_in   = out_kind_ff;
      out_byte_in   = out_byte_ff;
      out_len_in    = out_len_ff;
      out_ovf_in    = out_ovf_ff;
      out_last_in   = out_last_ff;

      if (csr_valid && csr_ready) begin
         attached_in = csr_attached;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in  = req_op;
               fin_in = req_final_byte;
               if (req_op == OP_RECV && req_data_byte == CH_CR) begin
                  byte_in = CH_LF;
               end else begin
                  byte_in = req_data_byte;
               end
               if (req_op == OP_RECV || req_op == OP_WRITE) begin
                  state_in = (byte_in == CH_LF) ? ST_PUSH_CR : ST_PUSH_BYTE;
               end else if (req_op == OP_TXRDY) begin
                  state_in = ST_TXRDY;
               end
            end
         end
         ST_PUSH_CR, ST_PUSH_BYTE: begin
            send_wr_data = (state_ff == ST_PUSH_CR) ? CH_CR : byte_ff;
            if (send_count_ff == SEND_FULL) begin
               drop_in = 1'b1;
            end else begin
               send_wr_en    = 1'b1;
               tail_in       = (tail_ff == SEND_LAST) ? '0 : tail_ff + SAW'(1);
               send_count_in = send_count_ff + SCW'(1);
            end
            state_in = (state_ff == ST_PUSH_CR) ? ST_PUSH_BYTE : ST_START;
         end
         ST_START: begin
            if (op_ff == OP_WRITE && !fin_ff) begin
               state_in = ST_IDLE;
            end else if (send_count_ff != '0 && !busy_ff) begin
               busy_in  = 1'b1;
               state_in = ST_SEND;
            end else begin
               state_in = (op_ff == OP_RECV) ? ST_LINE : ST_IDLE;
            end
         end
         ST_TXRDY: begin
            if (!attached_ff || send_count_ff == '0) begin
               busy_in  = 1'b0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_kind_in   = KIND_TX;
               out_byte_in   = send_rd_data;
               out_len_in    = '0;
               out_ovf_in    = drop_ff;
               out_last_in   = !(op_ff == OP_RECV && attached_ff && byte_ff == CH_LF);
               drop_in       = 1'b0;
               head_in       = (head_ff == SEND_LAST) ? '0 : head_ff + SAW'(1);
               send_count_in = send_count_ff - SCW'(1);
               state_in      = (op_ff == OP_RECV) ? ST_LINE : ST_IDLE;
            end
         end
         ST_LINE: begin
            if (!attached_ff) begin
               state_in = ST_IDLE;
            end else if (byte_ff != CH_LF) begin
               if (line_count_ff == LINE_FULL) begin
                  drop_in = 1'b1;
               end else begin
                  line_wr_en    = 1'b1;
                  line_count_in = line_count_ff + LCW'(1);
               end
               state_in = ST_IDLE;
            end else if (line_count_ff == '0) begin
               state_in = ST_MARK;
            end else begin
               line_idx_in = '0;
               state_in    = ST_LINE_EMIT;
            end
         end
         ST_LINE_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_LINE;
               out_byte_in  = line_rd_data;
               out_len_in   = '0;
               out_ovf_in   = drop_ff;
               out_last_in  = 1'b0;
               drop_in      = 1'b0;
               if (LCW'(line_idx_ff) + LCW'(1) == line_count_ff) begin
                  state_in = ST_MARK;
               end else begin
                  line_idx_in = line_idx_ff + LAW'(1);
               end
            end
         end
         ST_MARK: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_kind_in   = KIND_END;
               out_byte_in   = '0;
               out_len_in    = line_len_wide[LEN_W-1:0];
               out_ovf_in    = drop_ff;
               out_last_in   = 1'b1;
               drop_in       = 1'b0;
               line_count_in = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         attached_ff   <= 1'b0;
         busy_ff       <= 1'b0;
         drop_ff       <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         send_count_ff <= '0;
         line_count_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         attached_ff   <= attached_in;
         busy_ff       <= busy_in;
         drop_ff       <= drop_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         send_count_ff <= send_count_in;
         line_count_ff <= line_count_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      byte_ff     <= byte_in;
      fin_ff      <= fin_in;
      line_idx_ff <= line_idx_in;
      out_kind_ff <= out_kind_in;
      out_byte_ff <= out_byte_in;
      out_len_ff  <= out_len_in;
      out_ovf_ff  <= out_ovf_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = out_kind_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_line_length = out_len_ff;
   assign rsp_overflow    = out_ovf_ff;
   assign rsp_last        = out_last_ff;

   // queue and line counts stay within their stores
   a_send_count: assert property (@(posedge clock) disable iff (reset)
      send_count_ff <= SEND_FULL)
      else $error("transmit count beyond depth");

   a_line_count: assert property (@(posedge clock) disable iff (reset)
      line_count_ff <= LINE_FULL)
      else $error("line count beyond depth");

   // a send only happens with data queued
   a_send_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEND |-> send_count_ff != '0)
      else $error("send from empty queue");

   // transmitter goes idle only on a ready request
   a_busy_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> $past(state_ff) == ST_TXRDY)
      else $error("transmitter idle outside ready handling");

   // line results only while attached
   a_line_attached: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff == KIND_LINE |-> attached_ff)
      else $error("line byte while detached");

endmodule

// ===== sim/console_line_discipline_core_tb.sv =====
// ----------------------------------------------------------------------------
// console_line_discipline_core_tb
// self-checking bench for the console line discipline: random and directed
// received bytes, software writes and transmitter-ready requests are fed in,
// every result is compared with a cycle-free model of echo, cr lf expansion,
// transmit queue pacing and line delivery, under random stalls on both sides
// ----------------------------------------------------------------------------
package cld_tb_pkg;
   import cld_pkg::*;

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       ch;
      logic [LEN_W-1:0] len;
      logic             ovf;
      logic             last;
   } console_out_type;

   class console_tracker_type;
      logic [7:0]   tx_fifo [DEF_SEND_DEPTH];
      int unsigned  tx_head;
      int unsigned  tx_count;
      bit           tx_busy;
      logic [7:0]   line_buf [DEF_LINE_DEPTH];
      int unsigned  line_len;
      bit           attached;
      bit           drop_seen;
      console_out_type due [$];
      int           errors;
      int           n_requests;
      int           n_results;
      int           n_lines;
      int           n_flagged;

      function new();
         tx_head    = 0;
         tx_count   = 0;
         tx_busy    = 1'b0;
         line_len   = 0;
         attached   = 1'b0;
         drop_seen  = 1'b0;
         errors     = 0;
         n_requests = 0;
         n_results  = 0;
         n_lines    = 0;
         n_flagged  = 0;
      endfunction

      task report(input string msg);
         errors++;
         $display("MISMATCH: %s", msg);
      endtask

      function void set_attached(input bit v);
         attached = v;
      endfunction

      function void emit(input logic [1:0] kind, input logic [7:0] ch, input int unsigned len);
         console_out_type r;
         r.kind    = kind;
         r.ch      = ch;
         r.len     = LEN_W'(len);
         r.ovf     = drop_seen;
         r.last    = 1'b0;
         drop_seen = 1'b0;
         due.push_back(r);
      endfunction

      function void queue_byte(input logic [7:0] b);
         if (tx_count >= DEF_SEND_DEPTH) begin
            drop_seen = 1'b1;
         end else begin
            tx_fifo[(tx_head + tx_count) % DEF_SEND_DEPTH] = b;
            tx_count++;
         end
      endfunction

      function void queue_expanded(input logic [7:0] b);
         if (b == CH_LF) begin
            queue_byte(CH_CR);
         end
         queue_byte(b);
      endfunction

      function void send_head();
         logic [7:0] b;
         b       = tx_fifo[tx_head];
         tx_head = (tx_head + 1) % DEF_SEND_DEPTH;
         tx_count--;
         emit(KIND_TX, b, 0);
      endfunction

      function void try_start();
         if (tx_count != 0 && !tx_busy) begin
            tx_busy = 1'b1;
            send_head();
         end
      endfunction

      function void note_request(input logic [1:0] op, input logic [7:0] d, input logic fin);
         int unsigned     first;
         int unsigned     i;
         logic [7:0]      c;
         console_out_type r;
         first = due.size();
         c     = d;
         n_requests++;
         case (op)
            OP_RECV: begin
               if (c == CH_CR) begin
                  c = CH_LF;
               end
               queue_expanded(c);
               try_start();
               if (attached) begin
                  if (c != CH_LF) begin
                     if (line_len >= DEF_LINE_DEPTH) begin
                        drop_seen = 1'b1;
                     end else begin
                        line_buf[line_len] = c;
                        line_len++;
                     end
                  end else begin
                     for (i = 0; i < line_len; i++) begin
                        emit(KIND_LINE, line_buf[i], 0);
                     end
                     emit(KIND_END, 8'h00, line_len);
                     line_len = 0;
                     n_lines++;
                  end
               end
            end
            OP_WRITE: begin
               queue_expanded(c);
               if (fin) begin
                  try_start();
               end
            end
            OP_TXRDY: begin
               if (!attached || tx_count == 0) begin
                  tx_busy = 1'b0;
               end else begin
                  send_head();
               end
            end
            default: ;
         endcase
         if (due.size() > first) begin
            r      = due.pop_back();
            r.last = 1'b1;
            due.push_back(r);
         end
      endfunction

      task check_result(input console_out_type got);
         console_out_type want;
         n_results++;
         if (got.ovf === 1'b1) begin
            n_flagged++;
         end
         if (due.size() == 0) begin
            report($sformatf("result %0d: kind %0d byte %02h with nothing expected",
                             n_results, got.kind, got.ch));
            return;
         end
         want = due.pop_front();
         if (got.kind !== want.kind) begin
            report($sformatf("result %0d: kind %0d, want %0d", n_results, got.kind, want.kind));
         end
         if (got.ch !== want.ch) begin
            report($sformatf("result %0d: byte %02h, want %02h", n_results, got.ch, want.ch));
         end
         if (got.len !== want.len) begin
            report($sformatf("result %0d: length %0d, want %0d", n_results, got.len, want.len));
         end
         if (got.ovf !== want.ovf) begin
            report($sformatf("result %0d: overflow %b, want %b", n_results, got.ovf, want.ovf));
         end
         if (got.last !== want.last) begin
            report($sformatf("result %0d: last %b, want %b", n_results, got.last, want.last));
         end
      endtask
   endclass
endpackage

module console_line_discipline_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cld_pkg::*;
   import cld_tb_pkg::*;

   localparam logic [1:0] OP_UNUSED     = 2'd3;
   localparam int         SETTLE_CYCLES = 48;
   localparam int         RANDOM_ITEMS  = 400;

   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             req_valid      = 1'b0;
   logic             req_ready;
   logic [1:0]       req_op         = OP_RECV;
   logic [7:0]       req_data_byte  = 8'h00;
   logic             req_final_byte = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [1:0]       rsp_kind;
   logic [7:0]       rsp_out_byte;
   logic [LEN_W-1:0] rsp_line_length;
   logic             rsp_overflow;
   logic             rsp_last;
   logic             csr_valid      = 1'b0;
   logic             csr_ready;
   logic             csr_attached   = 1'b0;

   console_tracker_type sb = new();
   console_out_type     seen;
   int             gap_pct    = 20;
   int             stall_pct  = 20;
   int             fed        = 0;
   bit             hold_done  = 1'b0;
   int             hold_left  = 0;
   int             stall_left = 0;

   console_line_discipline_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_data_byte   (req_data_byte),
      .req_final_byte  (req_final_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_line_length (rsp_line_length),
      .rsp_overflow    (rsp_overflow),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_attached    (csr_attached)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen.kind = rsp_kind;
         seen.ch   = rsp_out_byte;
         seen.len  = rsp_line_length;
         seen.ovf  = rsp_overflow;
         seen.last = rsp_last;
         sb.check_result(seen);
      end
   end

   // result side: one long hold-off mid run, otherwise random stall bursts
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else if (!hold_done && sb.n_requests >= 150) begin
            hold_done = 1'b1;
            hold_left = 399;
            rsp_ready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready = 1'b0;
         end else if ($urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(0, 8);
            rsp_ready  = 1'b0;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   task automatic send_req(input logic [1:0] op, input logic [7:0] d, input logic fin);
      int gap;
      gap = 0;
      if ($urandom_range(99) < gap_pct) begin
         gap = $urandom_range(1, 9);
      end
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid      = 1'b1;
      req_op         = op;
      req_data_byte  = d;
      req_final_byte = fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(op, d, fin);
      if (op != OP_UNUSED) begin
         fed++;
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_attached(input bit v);
      @(negedge clock);
      csr_valid    = 1'b1;
      csr_attached = v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_attached(v);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // transmitter-ready requests roughly keeping pace with what was sent
   task automatic pace_tx();
      repeat (2) begin
         if (sb.tx_busy && $urandom_range(99) < 70) begin
            send_req(OP_TXRDY, 8'($urandom), 1'($urandom));
         end
      end
   endtask

   function automatic logic [7:0] text_char();
      logic [7:0] c;
      if ($urandom_range(7) != 0) begin
         return 8'($urandom_range(8'h20, 8'h7E));
      end
      do c = 8'($urandom); while (c == CH_CR || c == CH_LF);
      return c;
   endfunction

   task automatic chat_line(input bit long_line);
      int n;
      int m;
      n = long_line ? $urandom_range(33, 40) : $urandom_range(0, 10);
      for (int i = 0; i < n; i++) begin
         send_req(OP_RECV, text_char(), 1'($urandom));
         pace_tx();
         if ($urandom_range(9) == 0) begin
            m = $urandom_range(1, 5);
            for (int j = 0; j < m; j++) begin
               send_req(OP_WRITE, ($urandom_range(5) == 0) ? CH_LF : 8'($urandom), j == m - 1);
               pace_tx();
            end
         end
      end
      send_req(OP_RECV, $urandom_range(1) ? CH_CR : CH_LF, 1'($urandom));
      pace_tx();
   endtask

   // software write burst that can overrun the queue, then drain
   task automatic flood_burst();
      int n;
      n = $urandom_range(20, 45);
      for (int i = 0; i < n; i++) begin
         send_req(OP_WRITE, ($urandom_range(7) == 0) ? CH_LF : 8'($urandom),
                  i == n - 1 || $urandom_range(9) == 0);
      end
      for (int k = 0; k < 40 && sb.tx_count != 0 && sb.attached; k++) begin
         send_req(OP_TXRDY, 8'h00, 1'b0);
      end
      send_req(OP_TXRDY, 8'($urandom), 1'($urandom));
   endtask

   initial begin
      int rand_start;
      int phase;
      int budget;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // detached: echo still starts transmission, ready only idles
      write_attached(1'b0);
      send_req(OP_RECV, 8'h61, 1'b0);
      send_req(OP_RECV, CH_CR, 1'b1);
      send_req(OP_TXRDY, 8'hFF, 1'b1);
      send_req(OP_WRITE, 8'h00, 1'b0);
      send_req(OP_WRITE, 8'hFF, 1'b1);
      send_req(OP_UNUSED, 8'hAA, 1'b1);
      send_req(OP_RECV, CH_LF, 1'b0);
      send_req(OP_TXRDY, 8'h00, 1'b0);
      settle();

      write_attached(1'b1);
      send_req(OP_WRITE, CH_LF, 1'b1);
      while (sb.tx_count != 0) send_req(OP_TXRDY, 8'h00, 1'b0);
      send_req(OP_TXRDY, 8'h00, 1'b0);
      send_req(OP_RECV, 8'h68, 1'b0);
      send_req(OP_RECV, 8'h69, 1'b1);
      send_req(OP_RECV, CH_CR, 1'b0);
      send_req(OP_RECV, CH_LF, 1'b1);
      send_req(OP_RECV, 8'hFF, 1'b0);
      send_req(OP_RECV, 8'h00, 1'b1);
      send_req(OP_RECV, CH_LF, 1'b0);
      while (sb.tx_count != 0) send_req(OP_TXRDY, 8'h00, 1'b0);

      rand_start = fed;
      phase      = 0;
      while (fed - rand_start < RANDOM_ITEMS) begin
         settle();
         if (fed - rand_start >= RANDOM_ITEMS - 80) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1) ? 15 : 40;
            stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(1) ? 15 : 40;
         end
         write_attached(phase % 3 != 2);
         budget = fed + 50;
         while (fed < budget) begin
            case (phase % 4)
               0: chat_line($urandom_range(7) == 0);
               1: flood_burst();
               2: send_req(2'($urandom_range(3)), 8'($urandom), 1'($urandom));
               default: chat_line($urandom_range(1));
            endcase
         end
         phase++;
      end
      settle();

      $display("covered %0d requests over %0d phases, %0d results, %0d lines delivered",
               sb.n_requests, phase, sb.n_results, sb.n_lines);
      $display("%0d results carried a dropped-byte flag, %0d mismatches",
               sb.n_flagged, sb.errors);
      if (sb.errors == 0) begin
         $display("console_line_discipline_core_tb: done, clean");
      end else begin
         $display("console_line_discipline_core_tb: done, errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", sb.due.size());
      $display("console_line_discipline_core_tb: done, errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/cld_pkg.sv
hdl/cld_byte_ram.sv
hdl/console_line_discipline_core.sv
sim/console_line_discipline_core_tb.sv
